/* design/sitelist_pkg.sv */
// shared types and constants for the site list block
// command and status codes, controller/datapath command and status structs
// no dependencies
package sitelist_pkg;

  // default sizes
  localparam int CAPACITY_DEF    = 1024;
  localparam int INDEX_BITS_DEF  = 20;
  localparam int RANDOM_BITS_DEF = 16;

  // command codes carried in s_tuser
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_PICK   = 2'd3
  } cmd_e_t;

  // result status codes carried in m_tuser
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e_t;

  // source of the store read address
  typedef enum logic [1:0] {
    RD_SCAN = 2'd0,
    RD_PICK = 2'd1,
    RD_LAST = 2'd2
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      latch_in;
    logic      add_write;
    logic      scan_start;
    logic      scan_run;
    logic      pick_mul;
    rd_sel_t   rd_sel;
    logic      take_pick;
    logic      move_write;
    logic      load_result;
    status_e_t res_status;
    logic      res_listed;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e_t op;
    logic   full;
    logic   empty;
    logic   found;
    logic   exhausted;
    logic   out_free;
  } ctl_stat_t;

endpackage

/* design/sitelist_ram.sv */
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies beyond the package defaults
module sitelist_ram #(
  parameter int  WIDTH  = sitelist_pkg::INDEX_BITS_DEF,
  parameter int  DEPTH  = sitelist_pkg::CAPACITY_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/sitelist_dp.sv */
// datapath of the site list: input latch, fill count, linear scan, pick slot
// multiply, site store ram and result output register
// depends on sitelist_pkg and sitelist_ram
module sitelist_dp #(
  parameter int  CAPACITY    = sitelist_pkg::CAPACITY_DEF,
  parameter int  INDEX_BITS  = sitelist_pkg::INDEX_BITS_DEF,
  parameter int  RANDOM_BITS = sitelist_pkg::RANDOM_BITS_DEF,
  localparam int ADDR_BITS   = $clog2(CAPACITY),
  localparam int CNT_BITS    = $clog2(CAPACITY + 1),
  localparam int IN_W        = ((INDEX_BITS + RANDOM_BITS + 7) / 8) * 8,
  localparam int OUT_W       = ((1 + INDEX_BITS + CNT_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sitelist_pkg::ctl_cmd_t  cmd,
  output sitelist_pkg::ctl_stat_t stat,
  input  logic [IN_W-1:0]        s_tdata,
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_W-1:0]       m_tdata,
  output logic [1:0]             m_tuser
);

  // latched item
  sitelist_pkg::cmd_e_t   op;
  logic [INDEX_BITS-1:0]  key;
  logic [RANDOM_BITS-1:0] frac;

  // list state
  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  count_dec;

  // scan state
  logic [CNT_BITS-1:0]  ptr;
  logic                 pend;
  logic [ADDR_BITS-1:0] slot_q;
  logic [ADDR_BITS-1:0] match_slot;
  logic                 issue;
  logic                 found;
  logic                 exhausted;

  // pick
  logic [RANDOM_BITS+CNT_BITS-1:0] prod;
  logic [ADDR_BITS-1:0]            pick_slot;
  logic [INDEX_BITS-1:0]           picked;

  // store ports
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [INDEX_BITS-1:0] wr_data;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [INDEX_BITS-1:0] rd_data;

  // output register
  sitelist_pkg::status_e_t out_status;
  logic                    out_listed;
  logic [INDEX_BITS-1:0]   out_picked;
  logic [CNT_BITS-1:0]     out_count;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op   <= sitelist_pkg::cmd_e_t'(s_tuser);
      key  <= s_tdata[INDEX_BITS-1:0];
      frac <= s_tdata[INDEX_BITS +: RANDOM_BITS];
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.add_write) begin
      count <= count + 1'b1;
    end else if (cmd.move_write) begin
      count <= count_dec;
    end
  end

  assign count_dec = count - 1'b1;

  // linear scan, one read issued per cycle, compared in the cycle after the read
  assign issue     = cmd.scan_run && (ptr < count);
  assign found     = pend && (rd_data == key);
  assign exhausted = (ptr >= count) && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      pend <= 1'b0;
    end else if (cmd.scan_start) begin
      ptr  <= '0;
      pend <= 1'b0;
    end else if (cmd.scan_run) begin
      pend <= issue;
      if (issue) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      slot_q <= ptr[ADDR_BITS-1:0];
    end
    if (cmd.scan_run && found) begin
      match_slot <= slot_q;
    end
  end

  // pick slot = (fraction * count) >> random bits, always below count
  assign prod = {{CNT_BITS{1'b0}}, frac} * {{RANDOM_BITS{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (cmd.pick_mul) begin
      pick_slot <= prod[RANDOM_BITS +: ADDR_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      picked <= '0;
    end else if (cmd.take_pick) begin
      picked <= rd_data;
    end
  end

  // store address and data selection
  always_comb begin
    unique case (cmd.rd_sel)
      sitelist_pkg::RD_SCAN: rd_addr = ptr[ADDR_BITS-1:0];
      sitelist_pkg::RD_PICK: rd_addr = pick_slot;
      sitelist_pkg::RD_LAST: rd_addr = count_dec[ADDR_BITS-1:0];
      default:               rd_addr = ptr[ADDR_BITS-1:0];
    endcase
  end

  assign wr_en   = cmd.add_write || cmd.move_write;
  assign wr_addr = cmd.add_write ? count[ADDR_BITS-1:0] : match_slot;
  assign wr_data = cmd.add_write ? key : rd_data;

  sitelist_ram #(
    .WIDTH (INDEX_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_status <= cmd.res_status;
      out_listed <= cmd.res_listed;
      out_picked <= picked;
      out_count  <= count;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = OUT_W'({out_count, out_picked, out_listed});

  // status to the controller
  assign stat.op        = op;
  assign stat.full      = (count == CNT_BITS'(CAPACITY));
  assign stat.empty     = (count == '0);
  assign stat.found     = found;
  assign stat.exhausted = exhausted;
  assign stat.out_free  = !m_tvalid || m_tready;

  // checks
  a_add_room: assert property (@(posedge clk) disable iff (rst)
    cmd.add_write |-> (count != CNT_BITS'(CAPACITY)))
    else $error("add written into a full list");

  a_move_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.move_write |-> (count != '0))
    else $error("remove from an empty list");

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    cmd.add_write |=> (count == $past(count) + 1'b1))
    else $error("fill count did not grow on add");

  a_scan_excl: assert property (@(posedge clk) disable iff (rst)
    !(found && exhausted))
    else $error("scan both found and exhausted");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> (!m_tvalid || m_tready))
    else $error("result loaded over a waiting beat");

endmodule

/* design/sitelist_ctrl.sv */
// controller state machine of the site list
// sequences add, remove, query and pick over the datapath
// depends on sitelist_pkg
module sitelist_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  sitelist_pkg::ctl_stat_t stat,
  output sitelist_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    IDLE,
    DECODE,
    ADD_WR,
    SCAN,
    MOVE_RD,
    MOVE_WR,
    PICK_RD,
    PICK_TAKE,
    RESULT
  } state_t;

  state_t                  state;
  sitelist_pkg::status_e_t res_status;
  logic                    res_listed;

  // state and result code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      res_status <= sitelist_pkg::ST_OK;
      res_listed <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          res_status <= sitelist_pkg::ST_OK;
          res_listed <= 1'b0;
          if (s_tvalid) begin
            state <= DECODE;
          end
        end
        DECODE: begin
          unique case (stat.op) inside
            sitelist_pkg::CMD_ADD: begin
              if (stat.full) begin
                res_status <= sitelist_pkg::ST_FULL;
                state      <= RESULT;
              end else begin
                state <= ADD_WR;
              end
            end
            sitelist_pkg::CMD_REMOVE, sitelist_pkg::CMD_QUERY: begin
              state <= SCAN;
            end
            sitelist_pkg::CMD_PICK: begin
              if (stat.empty) begin
                res_status <= sitelist_pkg::ST_EMPTY;
                state      <= RESULT;
              end else begin
                state <= PICK_RD;
              end
            end
            default: state <= RESULT;
          endcase
        end
        ADD_WR: state <= RESULT;
        SCAN: begin
          if (stat.found) begin
            if (stat.op == sitelist_pkg::CMD_QUERY) begin
              res_listed <= 1'b1;
              state      <= RESULT;
            end else begin
              state <= MOVE_RD;
            end
          end else if (stat.exhausted) begin
            if (stat.op != sitelist_pkg::CMD_QUERY) begin
              res_status <= sitelist_pkg::ST_NOT_FOUND;
            end
            state <= RESULT;
          end
        end
        MOVE_RD:   state <= MOVE_WR;
        MOVE_WR:   state <= RESULT;
        PICK_RD:   state <= PICK_TAKE;
        PICK_TAKE: state <= RESULT;
        RESULT: begin
          if (stat.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // commands decoded from state
  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = sitelist_pkg::RD_SCAN;
    cmd.res_status = res_status;
    cmd.res_listed = res_listed;
    s_tready       = (state == IDLE);
    cmd.latch_in   = s_tready && s_tvalid;
    unique case (state)
      IDLE: ;
      DECODE: begin
        cmd.scan_start = 1'b1;
        cmd.pick_mul   = 1'b1;
      end
      ADD_WR:    cmd.add_write = 1'b1;
      SCAN:      cmd.scan_run  = 1'b1;
      MOVE_RD:   cmd.rd_sel    = sitelist_pkg::RD_LAST;
      MOVE_WR:   cmd.move_write = 1'b1;
      PICK_RD:   cmd.rd_sel    = sitelist_pkg::RD_PICK;
      PICK_TAKE: cmd.take_pick = 1'b1;
      RESULT:    cmd.load_result = stat.out_free;
      default: ;
    endcase
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.latch_in |=> (state == DECODE))
    else $error("accepted beat not decoded");

  a_move_after_found: assert property (@(posedge clk) disable iff (rst)
    (state == MOVE_RD) |-> ($past(state) == SCAN && $past(stat.found)))
    else $error("move without a match");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |=> (state == IDLE))
    else $error("result load did not end the item");

endmodule

/* design/site_set_swap_remove_random_pick.sv */
// Unordered site list with swap-remove and random pick. One command beat in
// gives one result beat out; items are handled one at a time. An add with
// room steps through DECODE, ADD_WR and RESULT, a pick on a filled list
// through DECODE, PICK_RD, PICK_TAKE and RESULT, and remove or query through
// DECODE, SCAN and RESULT, the scan reading one stored entry per cycle through
// the single read port of the site store; a remove that matches adds MOVE_RD
// and MOVE_WR to move the last entry into the freed slot. A finished result
// waits in an output register, so the next command is accepted while the
// previous result is still pending. The store needs no clearing after reset:
// only data from slots below the fill count is ever used.
// depends on sitelist_pkg, sitelist_ctrl, sitelist_dp, sitelist_ram
module site_set_swap_remove_random_pick #(
  parameter int  CAPACITY    = sitelist_pkg::CAPACITY_DEF,
  parameter int  INDEX_BITS  = sitelist_pkg::INDEX_BITS_DEF,
  parameter int  RANDOM_BITS = sitelist_pkg::RANDOM_BITS_DEF,
  localparam int CNT_BITS    = $clog2(CAPACITY + 1),
  localparam int IN_W        = ((INDEX_BITS + RANDOM_BITS + 7) / 8) * 8,
  localparam int OUT_W       = ((1 + INDEX_BITS + CNT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // site_index, random_fraction
  input  logic [1:0]       s_tuser,   // command
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // is_listed, picked_site, entry_count
  output logic [1:0]       m_tuser    // status
);

  sitelist_pkg::ctl_cmd_t  cmd;
  sitelist_pkg::ctl_stat_t stat;

  // sequencer
  sitelist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store, scan and result path
  sitelist_dp #(
    .CAPACITY    (CAPACITY),
    .INDEX_BITS  (INDEX_BITS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
